FILE: src/tprl_pkg.sv
`default_nettype none

package tprl_pkg;

   localparam int CLK_W     = 27;
   localparam int CLK2_W    = CLK_W + 1;
   localparam int PERIOD_W  = 32;
   localparam int TICKS_W   = 32;
   localparam int OUT_W     = 16;
   localparam int CSR_IDX_W = 2;

   // floor(clk / 1000000) as (clk * RECIP) >> MHZ_SHIFT, exact for clk < 2^28
   localparam int RECIP_W   = 29;
   localparam logic [RECIP_W-1:0] MHZ_RECIP = 29'd281474977;
   localparam int MHZ_SHIFT = 48;
   localparam int MHZ_W     = 9;

   localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 27'd48000000;

   localparam logic [CSR_IDX_W-1:0] CSR_BUS_CLOCK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_CLOCK = 2'd1;

   // compare-subtract steps done by each divider stage
   localparam int DIV_STEPS = 4;

   typedef struct packed {
      logic               bad;
      logic [TICKS_W-1:0] ticks;
   } tick_item_type;

endpackage

`default_nettype wire

FILE: src/tprl_ticks.sv
`default_nettype none

module tprl_ticks (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tprl_pkg::CLK_W-1:0]     bus_clock_hz,
   input  wire logic [tprl_pkg::CLK_W-1:0]     core_clock_hz,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [tprl_pkg::PERIOD_W-1:0]  in_period,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output tprl_pkg::tick_item_type             out_item
);
   import tprl_pkg::*;

   localparam int PROD_W  = CLK2_W + RECIP_W;
   localparam int TFULL_W = PERIOD_W + MHZ_W;

   logic                  v1_ff;
   logic                  v2_ff;
   logic                  adv1;
   logic                  adv2;
   logic [CLK2_W-1:0]     clk_hz;
   logic [PROD_W-1:0]     clk_prod;
   logic [MHZ_W-1:0]      mhz_in;
   logic [MHZ_W-1:0]      mhz_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [TFULL_W-1:0]    ticks_full;
   tick_item_type         item_in;
   tick_item_type         item_ff;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   // timer clock runs at twice the bus clock when bus and core differ
   always_comb begin
      if (bus_clock_hz != core_clock_hz) begin
         clk_hz = {bus_clock_hz, 1'b0};
      end else begin
         clk_hz = {1'b0, bus_clock_hz};
      end
      clk_prod = PROD_W'(clk_hz) * PROD_W'(MHZ_RECIP);
      mhz_in   = clk_prod[MHZ_SHIFT +: MHZ_W];
   end

   always_comb begin
      ticks_full    = TFULL_W'(period_ff) * TFULL_W'(mhz_ff);
      item_in.ticks = ticks_full[TICKS_W-1:0];
      item_in.bad   = (ticks_full[TFULL_W-1:TICKS_W] != '0) || (ticks_full == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         period_ff <= in_period;
         mhz_ff    <= mhz_in;
      end
      if (adv2) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

FILE: src/tprl_div.sv
`default_nettype none

module tprl_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 1,
   parameter int STEPS  = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [NUM_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int STAGES = (NUM_W + STEPS - 1) / STEPS;

   logic              v_ff    [STAGES];
   logic [DEN_W-1:0]  rem_ff  [STAGES];
   logic [NUM_W-1:0]  num_ff  [STAGES];
   logic [DEN_W-1:0]  den_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [STAGES:0]   adv;

   assign adv[STAGES] = out_ready;
   assign in_ready    = adv[0];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic              v_src;
      logic [DEN_W-1:0]  rem_src;
      logic [NUM_W-1:0]  num_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  num_in;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign num_src  = in_num;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign num_src  = num_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      assign adv[s] = !v_ff[s] || adv[s+1];

      // each step shifts one numerator bit into the remainder, quotient bits fill from the bottom
      always_comb begin
         logic [DEN_W:0] trial;
         rem_in = rem_src;
         num_in = num_src;
         trial  = '0;
         for (int k = 0; k < STEPS; k++) begin
            if (s * STEPS + k < NUM_W) begin
               trial  = {rem_in, num_in[NUM_W-1]};
               num_in = {num_in[NUM_W-2:0], 1'b0};
               if (trial >= {1'b0, den_src}) begin
                  trial     = trial - {1'b0, den_src};
                  num_in[0] = 1'b1;
               end
               rem_in = trial[DEN_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s]  <= rem_in;
            num_ff[s]  <= num_in;
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_quo   = num_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (v_ff[STAGES-1] && (den_ff[STAGES-1] != '0)) |-> (rem_ff[STAGES-1] < den_ff[STAGES-1]))
      else $error("divider remainder not below divisor");

   a_enter_first: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> v_ff[0])
      else $error("accepted request missing from first divider stage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (out_valid && !out_ready))
      else $error("divider stalls input while output is free");

endmodule

`default_nettype wire

FILE: src/timer_period_to_prescaler_reload.sv
`default_nettype none

// Converts a timer period in microseconds into prescaler and auto-reload values.
// Fully pipelined (two stages for the MHz scaling and tick multiply, nine and
// eight stages for the two restoring dividers at four quotient bits per stage,
// one output register): one request per cycle while rsp_ready does not stall
// the output. The user must write the clock registers through the csr port
// only while no request is in flight; the block itself does not enforce it.

module timer_period_to_prescaler_reload #(
   parameter int COUNTER_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [tprl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tprl_pkg::CLK_W-1:0]      csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tprl_pkg::PERIOD_W-1:0]   req_period_us,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tprl_pkg::OUT_W-1:0]           rsp_prescaler_value,
   output logic [tprl_pkg::OUT_W-1:0]           rsp_reload_value,
   output logic                                 rsp_out_of_range
);
   import tprl_pkg::*;

   localparam int WIDE_W = TICKS_W + 1;
   localparam logic [WIDE_W-1:0] LIMIT = (WIDE_W'(1) << COUNTER_BITS) - WIDE_W'(1);
   localparam logic [WIDE_W-1:0] HALF  = LIMIT >> 1;

   typedef struct packed {
      logic               bad;
      logic               div_big;
      logic [OUT_W-1:0]   pre;
      logic [TICKS_W-1:0] ticks;
   } div_item_type;

   localparam int SIDE1_W = $bits(tick_item_type);
   localparam int SIDE2_W = $bits(div_item_type);

   logic [CLK_W-1:0]    bus_clock_ff;
   logic [CLK_W-1:0]    core_clock_ff;

   logic                tk_valid;
   logic                tk_ready;
   tick_item_type       tk_item;

   logic [WIDE_W-1:0]   d1_num;
   logic [SIDE1_W-1:0]  d1_side_in;
   logic                d1_valid;
   logic                d1_ready;
   logic [WIDE_W-1:0]   d1_quo;
   logic [SIDE1_W-1:0]  d1_side_out;
   tick_item_type       d1_item;

   logic [WIDE_W-1:0]   den2;
   logic [WIDE_W-1:0]   pre_wide;
   div_item_type        d2_item_in;
   logic                d2_valid;
   logic                d2_ready;
   logic [TICKS_W-1:0]  d2_quo;
   logic [SIDE2_W-1:0]  d2_side_out;
   div_item_type        d2_item;

   logic                fail;
   logic [TICKS_W-1:0]  reload_wide;
   logic                rsp_adv;
   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_pre_in;
   logic [OUT_W-1:0]    rsp_pre_ff;
   logic [OUT_W-1:0]    rsp_reload_in;
   logic [OUT_W-1:0]    rsp_reload_ff;
   logic                rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_clock_ff  <= CLOCK_HZ_RESET;
         core_clock_ff <= CLOCK_HZ_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BUS_CLOCK:  bus_clock_ff  <= csr_wdata;
            CSR_CORE_CLOCK: core_clock_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tprl_ticks u_ticks (
      .clock         (clock),
      .reset         (reset),
      .bus_clock_hz  (bus_clock_ff),
      .core_clock_hz (core_clock_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_period     (req_period_us),
      .out_valid     (tk_valid),
      .out_ready     (tk_ready),
      .out_item      (tk_item)
   );

   // first divide: (ticks + limit/2) / limit
   assign d1_num     = WIDE_W'(tk_item.ticks) + HALF;
   assign d1_side_in = tk_item;

   tprl_div #(
      .NUM_W  (WIDE_W),
      .DEN_W  (COUNTER_BITS),
      .SIDE_W (SIDE1_W),
      .STEPS  (DIV_STEPS)
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tk_valid),
      .in_ready  (tk_ready),
      .in_num    (d1_num),
      .in_den    (LIMIT[COUNTER_BITS-1:0]),
      .in_side   (d1_side_in),
      .out_valid (d1_valid),
      .out_ready (d1_ready),
      .out_quo   (d1_quo),
      .out_side  (d1_side_out)
   );

   assign d1_item = tick_item_type'(d1_side_out);

   // divisor is one unless the tick count overflows the counter
   always_comb begin
      if (WIDE_W'(d1_item.ticks) > LIMIT) begin
         den2 = d1_quo + WIDE_W'(1);
      end else begin
         den2 = WIDE_W'(1);
      end
      pre_wide           = den2 - WIDE_W'(1);
      d2_item_in.bad     = d1_item.bad;
      d2_item_in.div_big = den2 > LIMIT;
      d2_item_in.pre     = pre_wide[OUT_W-1:0];
      d2_item_in.ticks   = d1_item.ticks;
   end

   tprl_div #(
      .NUM_W  (TICKS_W),
      .DEN_W  (WIDE_W),
      .SIDE_W (SIDE2_W),
      .STEPS  (DIV_STEPS)
   ) u_div_ticks (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_ready  (d1_ready),
      .in_num    (d1_item.ticks),
      .in_den    (den2),
      .in_side   (d2_item_in),
      .out_valid (d2_valid),
      .out_ready (d2_ready),
      .out_quo   (d2_quo),
      .out_side  (d2_side_out)
   );

   assign d2_item = div_item_type'(d2_side_out);

   always_comb begin
      fail = d2_item.bad || d2_item.div_big || (WIDE_W'(d2_quo) > LIMIT) || (d2_quo == '0);
      reload_wide = d2_quo - TICKS_W'(1);
      if (fail) begin
         rsp_pre_in    = '0;
         rsp_reload_in = '0;
      end else begin
         rsp_pre_in    = d2_item.pre;
         rsp_reload_in = reload_wide[OUT_W-1:0];
      end
   end

   // output register: hold the result until taken
   assign rsp_adv  = !rsp_valid_ff || rsp_ready;
   assign d2_ready = rsp_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_adv) begin
         rsp_pre_ff    <= rsp_pre_in;
         rsp_reload_ff <= rsp_reload_in;
         rsp_oor_ff    <= fail;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_prescaler_value = rsp_pre_ff;
   assign rsp_reload_value    = rsp_reload_ff;
   assign rsp_out_of_range    = rsp_oor_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> ((rsp_prescaler_value == '0) && (rsp_reload_value == '0)))
      else $error("out-of-range result carries nonzero values");

endmodule

`default_nettype wire
